// File: sv/gumbel_moment_fit_core_defines.svh
// Assertion macros for the Gumbel moment fit core.
// Used by the top level; relies on clk and rst in the including module.
`ifndef GUMBEL_MOMENT_FIT_CORE_DEFINES_SVH
`define GUMBEL_MOMENT_FIT_CORE_DEFINES_SVH
// Antecedent implies consequent in the same cycle.
`define GMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the following cycle.
`define GMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/gmf_pkg.sv
// Shared types and constants of the Gumbel moment fit core.
// No dependencies; imported by gmf_div and gumbel_moment_fit_core.
package gmf_pkg;
  localparam int DVD_W = 60;
  localparam int DVS_W = 29;
  localparam int CNT_W = $clog2(DVD_W);

  localparam logic signed [17:0] BETA_K = 18'sd51098;
  localparam logic signed [17:0] MU_K   = 18'sd37827;

  localparam logic [1:0] CFG_PRIOR_MEAN  = 2'd0;
  localparam logic [1:0] CFG_PRIOR_STDEV = 2'd1;
  localparam logic [1:0] CFG_MAX_CHANGE  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_VV, S_WV, S_ACC1, S_ACC2, S_CHECK, S_DIVM, S_DIVS, S_MSQ,
    S_VAR, S_SQRT, S_CMP, S_B1, S_B2, S_B3, S_B4, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;
endpackage

// File: sv/gumbel_moment_fit_core.sv
// Top level of the Gumbel method-of-moments fit core.
// Depends on gmf_pkg, gmf_div and gumbel_moment_fit_core_defines.svh.
//
// The core takes weighted samples (Q1.16 weight, Q8.8 value) one transaction at a
// time and keeps running sums of weight, weight*value and weight*value squared.
// Each sample uses the single shared multiplier in S_VV, S_WV and S_ACC1 and is
// summed in S_ACC2; no new sample is taken until the core is idle again. On the
// sample marked by tlast the core fits the batch unless the weight sum is zero:
// two divisions on the bit-serial divider, a square root, a compare and, if the
// estimate moved by at least max_change, the beta and mu steps S_B1 to S_B4 on
// the multiplier. It then presents one result transaction (changed and no_weight
// in tuser, the held estimates in tdata) and clears the sums. The result sits in
// an output register, so the next batch may start while it waits. Writing
// prior_mean or prior_stdev loads the held estimate and refreshes beta and mu
// through S_B1 to S_B4; configuration is taken only while idle.
`include "gumbel_moment_fit_core_defines.svh"
module gumbel_moment_fit_core import gmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // weight[16:0], sample_value[32:17], zero fill
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // est_mean, est_stdev, loc_mu, scale_beta
  output logic [1:0]  m_tuser,   // changed, no_weight
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  state_t state, state_next;

  logic        [16:0] w;
  logic signed [15:0] v;
  logic               last;
  logic        [31:0] vsq;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;

  logic [43:0] acc_weighted;
  logic [59:0] acc_weighted_square;
  logic [28:0] acc_weight;

  logic        [15:0] max_change;
  logic signed [15:0] held_mean;
  logic        [15:0] held_stdev;
  logic signed [15:0] held_mu;
  logic        [15:0] held_beta;

  logic signed [15:0] mean;
  logic        [31:0] ev2;
  logic        [31:0] sq_x;
  logic        [31:0] sq_r;
  logic        [31:0] sq_b;
  logic        [3:0]  sq_cnt;
  logic        [16:0] beta;
  logic               from_cfg;
  logic               changed;
  logic               no_weight;

  div_ctl_t          div_in, div_out;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVD_W-1:0]  q;
  logic [44:0]       mag_round;

  logic [32:0]        sq_sum;
  logic signed [16:0] dm, ds;
  logic        [16:0] dm_abs, ds_abs;
  logic               move;
  logic        [15:0] mu_t;
  logic signed [16:0] mu_diff;
  logic        [31:0] msq;

  gmf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (div_in),
    .ctl_out  (div_out),
    .dividend (div_dividend),
    .divisor  (acc_weight),
    .quotient (q)
  );

  // Negative sums divide the magnitude rounded up, giving a floored mean.
  assign mag_round = 45'({1'b1, 44'd0} - {1'b0, acc_weighted}) + 45'(acc_weight) - 45'd1;

  assign sq_sum  = {1'b0, sq_r} + {1'b0, sq_b};
  assign msq     = prod[31:0];
  assign dm      = 17'(mean) - 17'(held_mean);
  assign ds      = $signed({1'b0, sq_r[15:0]}) - $signed({1'b0, held_stdev});
  assign dm_abs  = dm[16] ? 17'(-dm) : 17'(dm);
  assign ds_abs  = ds[16] ? 17'(-ds) : 17'(ds);
  assign move    = (dm_abs >= {1'b0, max_change}) || (ds_abs >= {1'b0, max_change});
  // The mu offset is beta * 0.5772, rounded to nearest.
  assign mu_t    = 16'((33'(prod[31:0]) + 33'd32768) >> 16);
  assign mu_diff = 17'(held_mean) - $signed({1'b0, mu_t});

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cfg_valid && (cfg_index == CFG_PRIOR_MEAN || cfg_index == CFG_PRIOR_STDEV)) begin
          state_next = S_B1;
        end else if (s_tvalid && s_tready) begin
          state_next = S_VV;
        end
      end
      S_VV:    state_next = S_WV;
      S_WV:    state_next = S_ACC1;
      S_ACC1:  state_next = S_ACC2;
      S_ACC2:  state_next = last ? S_CHECK : S_IDLE;
      S_CHECK: state_next = (acc_weight == '0) ? S_OUT : S_DIVM;
      S_DIVM:  if (div_out.done) state_next = S_DIVS;
      S_DIVS:  if (div_out.done) state_next = S_MSQ;
      S_MSQ:   state_next = S_VAR;
      S_VAR:   state_next = S_SQRT;
      S_SQRT:  if (sq_cnt == 4'd15) state_next = S_CMP;
      S_CMP:   state_next = move ? S_B1 : S_OUT;
      S_B1:    state_next = S_B2;
      S_B2:    state_next = S_B3;
      S_B3:    state_next = S_B4;
      S_B4:    state_next = from_cfg ? S_IDLE : S_OUT;
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshakes, multiplier operands and divider control.
  always_comb begin
    cfg_ready    = (state == S_IDLE);
    s_tready     = (state == S_IDLE) && !cfg_valid;
    mul_a        = '0;
    mul_b        = '0;
    div_in.start = 1'b0;
    div_in.done  = 1'b0;
    div_dividend = acc_weighted_square;
    case (state)
      S_VV: begin
        mul_a = 34'(v);
        mul_b = 18'(v);
      end
      S_WV: begin
        mul_a = 34'(v);
        mul_b = $signed({1'b0, w});
      end
      S_ACC1: begin
        mul_a = $signed({2'b0, vsq});
        mul_b = $signed({1'b0, w});
      end
      S_CHECK: begin
        div_in.start = (acc_weight != '0);
        div_dividend = acc_weighted[43] ? DVD_W'(mag_round) : DVD_W'(acc_weighted);
      end
      S_DIVM: div_in.start = div_out.done;
      S_MSQ: begin
        mul_a = 34'(mean);
        mul_b = 18'(mean);
      end
      S_B1: begin
        mul_a = $signed({18'b0, held_stdev});
        mul_b = BETA_K;
      end
      S_B3: begin
        mul_a = $signed({17'b0, beta});
        mul_b = MU_K;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      m_tvalid            <= 1'b0;
      acc_weighted        <= '0;
      acc_weighted_square <= '0;
      acc_weight          <= '0;
      max_change          <= '0;
      held_mean           <= '0;
      held_stdev          <= '0;
      held_mu             <= '0;
      held_beta           <= '0;
      from_cfg            <= 1'b0;
    end else begin
      state <= state_next;
      prod  <= mul_a * mul_b;
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            from_cfg <= 1'b1;
            case (cfg_index)
              CFG_PRIOR_MEAN:  held_mean  <= $signed(cfg_data);
              CFG_PRIOR_STDEV: held_stdev <= cfg_data;
              CFG_MAX_CHANGE:  max_change <= cfg_data;
              default: ;
            endcase
          end else if (s_tvalid) begin
            from_cfg <= 1'b0;
            w        <= s_tdata[16:0];
            v        <= $signed(s_tdata[32:17]);
            last     <= s_tlast;
          end
        end
        S_WV:   vsq <= prod[31:0];
        S_ACC1: acc_weighted <= acc_weighted + prod[43:0];
        S_ACC2: begin
          acc_weighted_square <= acc_weighted_square + 60'(prod[47:0]);
          acc_weight          <= acc_weight + 29'(w);
        end
        S_CHECK: begin
          no_weight <= (acc_weight == '0);
          changed   <= 1'b0;
        end
        S_DIVM: begin
          if (div_out.done) begin
            if (acc_weighted[43]) begin
              mean <= (q > DVD_W'(32768)) ? -16'sd32768 : 16'(-q);
            end else begin
              mean <= (q > DVD_W'(32767)) ? 16'sd32767 : 16'(q);
            end
          end
        end
        S_DIVS: if (div_out.done) ev2 <= (q[59:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
        S_VAR: begin
          sq_x   <= (ev2 > msq) ? ev2 - msq : 32'd0;
          sq_r   <= '0;
          sq_b   <= 32'h4000_0000;
          sq_cnt <= '0;
        end
        S_SQRT: begin
          if ({1'b0, sq_x} >= sq_sum) begin
            sq_x <= 32'({1'b0, sq_x} - sq_sum);
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b   <= sq_b >> 2;
          sq_cnt <= sq_cnt + 1'b1;
        end
        S_CMP: begin
          if (move) begin
            changed    <= 1'b1;
            held_mean  <= mean;
            held_stdev <= sq_r[15:0];
          end
        end
        S_B2: beta <= 17'((prod[33:0] + 34'd32768) >> 16);
        S_B4: begin
          held_beta <= beta[15:0];
          if (mu_diff > 17'sd32767) begin
            held_mu <= 16'sd32767;
          end else if (mu_diff < -17'sd32768) begin
            held_mu <= -16'sd32768;
          end else begin
            held_mu <= 16'(mu_diff);
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tuser             <= {no_weight, changed};
            m_tdata             <= {held_beta, held_mu, held_stdev, held_mean};
            acc_weighted        <= '0;
            acc_weighted_square <= '0;
            acc_weight          <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `GMF_ASSERT_NEXT(a_busy_after_sample, s_tvalid && s_tready, !s_tready, "sample taken while busy")
  `GMF_ASSERT_NEXT(a_busy_after_cfg, cfg_valid && cfg_ready && (cfg_index == CFG_PRIOR_MEAN || cfg_index == CFG_PRIOR_STDEV), !s_tready, "sample open after cfg")
  `GMF_ASSERT_NOW(a_noweight_unchanged, m_tvalid && m_tuser[1], !m_tuser[0], "changed with no weight")
endmodule

// File: sv/gmf_div.sv
// Restoring divider, one quotient bit per cycle, for the fit sequencer.
// Depends on gmf_pkg for widths and the control struct.
module gmf_div import gmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl_in,
  output div_ctl_t          ctl_out,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic [DVD_W-1:0]  quotient
);
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = done;
endmodule
